// ===== rtl/redf_pkg.sv =====
package redf_pkg;

  // Defaults for the top level parameters
  localparam int MAX_HALF_WINDOW_DEF = 5;
  localparam int PIXEL_BITS_DEF      = 8;

  // Config port: data is as wide as the widest register (half_window)
  localparam int CFG_DATA_BITS  = 3;
  localparam int CFG_INDEX_BITS = 1;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_USE_MAX     = 1'b0,
    CFG_HALF_WINDOW = 1'b1
  } cfg_index_t;

endpackage

// ===== rtl/redf_window.sv =====
module redf_window #(
  parameter int MAX_HALF_WINDOW = redf_pkg::MAX_HALF_WINDOW_DEF,
  parameter int PIXEL_BITS      = redf_pkg::PIXEL_BITS_DEF,
  localparam int DEPTH          = 2 * MAX_HALF_WINDOW + 1,
  localparam int SW             = $clog2(MAX_HALF_WINDOW + 1)
) (
  input  logic [DEPTH-1:0][PIXEL_BITS-1:0] store,
  input  logic [SW-1:0]                    center,
  input  logic [SW-1:0]                    half,
  input  logic                             use_max,
  output logic [PIXEL_BITS-1:0]            result
);
  import redf_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int NP = 1 << $clog2(DEPTH);

  logic [IW-1:0]         lo;
  logic [IW-1:0]         hi;
  logic [PIXEL_BITS-1:0] ident;
  logic [PIXEL_BITS-1:0] node [1:2*NP-1];

  // center <= MAX and half <= MAX, so hi never passes the last entry
  assign lo    = (center > half) ? IW'(center - half) : '0;
  assign hi    = IW'(center) + IW'(half);
  assign ident = use_max ? '0 : '1;

  // Leaves outside [lo, hi] take the neutral value, then a balanced tree
  always_comb begin
    for (int i = 0; i < NP; i++) begin
      if (i < DEPTH && IW'(i) >= lo && IW'(i) <= hi) begin
        node[NP+i] = store[i];
      end else begin
        node[NP+i] = ident;
      end
    end
    for (int k = NP - 1; k >= 1; k--) begin
      if (use_max) begin
        node[k] = (node[2*k+1] > node[2*k]) ? node[2*k+1] : node[2*k];
      end else begin
        node[k] = (node[2*k+1] < node[2*k]) ? node[2*k+1] : node[2*k];
      end
    end
  end

  assign result = node[1];

endmodule

// ===== rtl/row_erode_dilate_filter.sv =====
// Row erode/dilate filter: a sliding-window minimum (use_max = 0) or maximum
// (use_max = 1) over pixels x-s..x+s of one row, with positions off either end
// of the row clamped to the first or last pixel. Pixels come in on the src
// channel, the last pixel of a row flagged by row_end; results leave on the res
// channel lagging the input by s pixels, and the final result of a row carries
// row_done. Throughput is one pixel per cycle outside row-end drains and result
// stalls: the window store is a shift line of 2*MAX_HALF_WINDOW+1 registers and
// the min/max tree sits between it and the result register, so a pixel that
// yields at most one result stalls the source only while res_stall holds the
// result register. A row end drains the k outstanding results (k <= s+1, or up
// to MAX_HALF_WINDOW+1 after s shrank within the row) one per cycle from the
// store while res_stall is low; src_stall holds until the last one issues; an
// accepted pixel enters the store before its result is registered. half_window
// writes saturate into 1..MAX_HALF_WINDOW. Write config only while idle.
module row_erode_dilate_filter #(
  parameter int MAX_HALF_WINDOW = redf_pkg::MAX_HALF_WINDOW_DEF,
  parameter int PIXEL_BITS      = redf_pkg::PIXEL_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // config write port
  input  logic                                cfg_we,
  input  logic [redf_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [redf_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  // source pixel beats
  input  logic                                src_valid,
  output logic                                src_stall,
  input  logic [PIXEL_BITS-1:0]               pixel,
  input  logic                                row_end,
  // result beats
  output logic                                res_valid,
  input  logic                                res_stall,
  output logic [PIXEL_BITS-1:0]               value,
  output logic                                row_done
);
  import redf_pkg::*;

  localparam int DEPTH = 2 * MAX_HALF_WINDOW + 1;
  localparam int SW    = $clog2(MAX_HALF_WINDOW + 1);  // half window, center
  localparam int EW    = $clog2(MAX_HALF_WINDOW + 2);  // outstanding count
  localparam int CMPW  = (SW > CFG_DATA_BITS) ? SW : CFG_DATA_BITS;

  // config registers
  logic          use_max;
  logic [SW-1:0] half_window;

  // row state
  logic [DEPTH-1:0][PIXEL_BITS-1:0] store;
  logic                             row_open;    // a pixel of this row taken
  logic [EW-1:0]                    emit_count;  // taken, not yet output

  // drain job: outputs still owed from the current store contents,
  // window centers job_c, job_c-1, ... down to 0 when job_end is set
  logic          job_valid;
  logic [SW-1:0] job_c;
  logic          job_end;

  logic                  src_take;
  logic                  job_fire;
  logic                  job_last;
  logic [EW-1:0]         e_inc;
  logic                  emit_now;
  logic [PIXEL_BITS-1:0] win_result;

  // ---------------------------------------------------------------------
  // Config writes
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      use_max     <= 1'b0;
      half_window <= SW'(1);
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_USE_MAX: begin
          use_max <= cfg_data[0];
        end
        CFG_HALF_WINDOW: begin
          if (cfg_data == '0) begin
            half_window <= SW'(1);
          end else if (CMPW'(cfg_data) > CMPW'(MAX_HALF_WINDOW)) begin
            half_window <= SW'(MAX_HALF_WINDOW);
          end else begin
            half_window <= SW'(cfg_data);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Handshake control
  // ---------------------------------------------------------------------
  // a job issues one result per cycle whenever the result register frees up
  assign job_fire = job_valid && (!res_valid || !res_stall);
  assign job_last = !job_end || (job_c == '0);

  // the store may change only once its last owed result has been issued
  assign src_stall = job_valid && !(job_fire && job_last);
  assign src_take  = src_valid && !src_stall;

  // count including the new pixel, saturating at MAX+1
  assign e_inc    = (emit_count < EW'(MAX_HALF_WINDOW + 1)) ? emit_count + EW'(1)
                                                            : emit_count;
  assign emit_now = e_inc > EW'(half_window);

  // ---------------------------------------------------------------------
  // Window store: first pixel of a row fills every entry, later ones shift
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (src_take) begin
      if (!row_open) begin
        for (int i = 0; i < DEPTH; i++) begin
          store[i] <= pixel;
        end
      end else begin
        for (int i = DEPTH - 1; i > 0; i--) begin
          store[i] <= store[i-1];
        end
        store[0] <= pixel;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Row counters and drain job
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      row_open   <= 1'b0;
      emit_count <= '0;
      job_valid  <= 1'b0;
    end else begin
      if (job_fire) begin
        if (job_last) begin
          job_valid <= 1'b0;
        end else begin
          job_c <= job_c - SW'(1);
        end
      end
      if (src_take) begin
        if (row_end) begin
          row_open   <= 1'b0;
          emit_count <= '0;
        end else begin
          row_open   <= 1'b1;
          emit_count <= emit_now ? e_inc - EW'(1) : e_inc;
        end
        // a row end drains everything outstanding, centers e_inc-1 .. 0
        job_valid <= row_end || emit_now;
        job_c     <= SW'(e_inc - EW'(1));
        job_end   <= row_end;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Min/max over the clamped window, then the result register
  // ---------------------------------------------------------------------
  redf_window #(
    .MAX_HALF_WINDOW (MAX_HALF_WINDOW),
    .PIXEL_BITS      (PIXEL_BITS)
  ) u_window (
    .store   (store),
    .center  (job_c),
    .half    (half_window),
    .use_max (use_max),
    .result  (win_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (job_fire) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (job_fire) begin
      value    <= win_result;
      row_done <= job_end && (job_c == '0);
    end
  end

endmodule
